/* sv/csa_pkg.sv */
`default_nettype none
package csa_pkg;
   localparam int CoefWidthDef   = 16;
   localparam int AngleStagesDef = 16;
   localparam int SqrtStages = 32;
   localparam int AngleLimit = 12868;
   localparam logic signed [31:0] HalfPiZ = 32'sd1686629713;

   localparam logic [2:0] KIND_CIRCLE     = 3'd0;
   localparam logic [2:0] KIND_ELLIPSE    = 3'd1;
   localparam logic [2:0] KIND_PARABOLA   = 3'd2;
   localparam logic [2:0] KIND_HYPERBOLA  = 3'd3;
   localparam logic [2:0] KIND_DEGENERATE = 3'd4;

   function automatic logic [31:0] atan_entry(input int idx);
      logic [31:0] t;
      case (idx)
         0: t = 32'd843314856;
         1: t = 32'd497837829;
         2: t = 32'd263043836;
         3: t = 32'd133525158;
         4: t = 32'd67021686;
         5: t = 32'd33543515;
         6: t = 32'd16775850;
         7: t = 32'd8388437;
         8: t = 32'd4194282;
         9: t = 32'd2097149;
         10: t = 32'd1048575;
         11: t = 32'd524287;
         12: t = 32'd262143;
         13: t = 32'd131071;
         14: t = 32'd65535;
         15: t = 32'd32767;
         16: t = 32'd16383;
         17: t = 32'd8191;
         18: t = 32'd4095;
         19: t = 32'd2047;
         20: t = 32'd1023;
         21: t = 32'd511;
         22: t = 32'd255;
         23: t = 32'd127;
         24: t = 32'd63;
         25: t = 32'd31;
         26: t = 32'd15;
         27: t = 32'd7;
         28: t = 32'd3;
         29: t = 32'd1;
         default: t = 32'd0;
      endcase
      return t;
   endfunction
endpackage
`default_nettype wire

/* sv/csa_delay.sv */
`default_nettype none
module csa_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  wire logic             clock,
   input  wire logic             enable,
   input  wire logic [WIDTH-1:0] din,
   output logic      [WIDTH-1:0] dout
);
   logic [WIDTH-1:0] tap_ff [DEPTH+1];
   assign tap_ff[0] = din;
   for (genvar i = 0; i < DEPTH; i++) begin : g_tap
      logic [WIDTH-1:0] st_ff;
      always_ff @(posedge clock) begin
         if (enable) begin
            st_ff <= tap_ff[i];
         end
      end
      assign tap_ff[i+1] = st_ff;
   end
   assign dout = tap_ff[DEPTH];
endmodule
`default_nettype wire

/* sv/csa_div_chain.sv */
`default_nettype none
// unsigned restoring divider, one quotient bit per cell
module csa_div_chain #(
   parameter int NW = 48,
   parameter int DW = 36
) (
   input  wire logic          clock,
   input  wire logic          enable,
   input  wire logic [NW-1:0] num,
   input  wire logic [DW-1:0] den,
   output logic      [NW-1:0] quo
);
   logic [NW-1:0] q_w [NW+1];
   logic [DW:0]   r_w [NW+1];
   logic [DW-1:0] d_w [NW+1];
   assign q_w[0] = num;
   assign r_w[0] = '0;
   assign d_w[0] = den;
   for (genvar i = 0; i < NW; i++) begin : g_cell
      logic [NW-1:0] q_ff;
      logic [DW:0]   r_ff;
      logic [DW-1:0] d_ff;
      logic [DW+1:0] tr_w;
      logic [DW+1:0] df_w;
      assign tr_w = {r_w[i], q_w[i][NW-1]};
      assign df_w = tr_w - {2'b00, d_w[i]};
      always_ff @(posedge clock) begin
         if (enable) begin
            d_ff <= d_w[i];
            if (!df_w[DW+1]) begin
               r_ff <= df_w[DW:0];
               q_ff <= {q_w[i][NW-2:0], 1'b1};
            end else begin
               r_ff <= tr_w[DW:0];
               q_ff <= {q_w[i][NW-2:0], 1'b0};
            end
         end
      end
      assign q_w[i+1] = q_ff;
      assign r_w[i+1] = r_ff;
      assign d_w[i+1] = d_ff;
   end
   assign quo = q_w[NW];
endmodule
`default_nettype wire

/* sv/csa_sqrt_chain.sv */
`default_nettype none
// floor square root of a 64-bit value, one result bit per cell
module csa_sqrt_chain (
   input  wire logic        clock,
   input  wire logic        enable,
   input  wire logic [63:0] din,
   output logic      [31:0] root
);
   logic [63:0] v_w [33];
   logic [33:0] r_w [33];
   logic [31:0] q_w [33];
   assign v_w[0] = din;
   assign r_w[0] = '0;
   assign q_w[0] = '0;
   for (genvar i = 0; i < 32; i++) begin : g_cell
      logic [63:0] v_ff;
      logic [33:0] r_ff;
      logic [31:0] q_ff;
      logic [35:0] tr_w;
      logic [35:0] tm_w;
      assign tr_w = {r_w[i], v_w[i][63:62]};
      assign tm_w = tr_w - {2'b00, q_w[i], 2'b01};
      always_ff @(posedge clock) begin
         if (enable) begin
            v_ff <= {v_w[i][61:0], 2'b00};
            if (!tm_w[35]) begin
               r_ff <= tm_w[33:0];
               q_ff <= {q_w[i][30:0], 1'b1};
            end else begin
               r_ff <= tr_w[33:0];
               q_ff <= {q_w[i][30:0], 1'b0};
            end
         end
      end
      assign v_w[i+1] = v_ff;
      assign r_w[i+1] = r_ff;
      assign q_w[i+1] = q_ff;
   end
   assign root = q_w[32];
endmodule
`default_nettype wire

/* sv/csa_cordic_chain.sv */
`default_nettype none
module csa_cordic_chain #(
   parameter int STAGES = 16,
   parameter int XW = 48
) (
   input  wire logic                 clock,
   input  wire logic                 enable,
   input  wire logic signed [XW-1:0] x0,
   input  wire logic signed [XW-1:0] y0,
   input  wire logic signed [33:0]   z0,
   output logic signed      [33:0]   z_out
);
   import csa_pkg::*;
   logic signed [XW-1:0] x_w [STAGES+1];
   logic signed [XW-1:0] y_w [STAGES+1];
   logic signed [33:0]   z_w [STAGES+1];
   assign x_w[0] = x0;
   assign y_w[0] = y0;
   assign z_w[0] = z0;
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      localparam logic signed [33:0] Step = 34'(atan_entry(i));
      logic signed [XW-1:0] x_ff;
      logic signed [XW-1:0] y_ff;
      logic signed [33:0]   z_ff;
      always_ff @(posedge clock) begin
         if (enable) begin
            if (y_w[i] > 0) begin
               x_ff <= x_w[i] + (y_w[i] >>> i);
               y_ff <= y_w[i] - (x_w[i] >>> i);
               z_ff <= z_w[i] + Step;
            end else begin
               x_ff <= x_w[i] - (y_w[i] >>> i);
               y_ff <= y_w[i] + (x_w[i] >>> i);
               z_ff <= z_w[i] - Step;
            end
         end
      end
      assign x_w[i+1] = x_ff;
      assign y_w[i+1] = y_ff;
      assign z_w[i+1] = z_ff;
   end
   assign z_out = z_w[STAGES];
endmodule
`default_nettype wire

/* sv/conic_section_analyzer_unit.sv */
`default_nettype none
// Conic section analyser.
// Request channel: six signed coefficients A..F of A x^2 + Bxy + C y^2 + Dx + Ey + F,
// one port each, taken on a req_valid/req_ready transfer.
// Response channel: kind, discriminant, centre, rotation angle and semi-axes,
// one response transfer per request, in request order.
// Fully pipelined: one transfer per cycle in and out while rsp_ready is high.
// From the request transfer to rsp_valid a request passes two front stages,
// a 2*COEF_WIDTH+20 cell centre divider, three stages for saturation and fp,
// a COEF_WIDTH+68 cell axis divider, a radicand stage, a 32-cell square-root
// chain and the output register. The CORDIC chain runs beside them and is
// delayed to match.
// The whole pipe advances when the output register is empty or being taken;
// a receiver stall freezes every cell and drops req_ready in the same cycle,
// so no transfer is lost.
// Reset clears only the valid bits of the pipe; data cells need no reset.
// req_ready is high from the first cycle after reset.
module conic_section_analyzer_unit #(
   parameter int COEF_WIDTH   = csa_pkg::CoefWidthDef,
   parameter int ANGLE_STAGES = csa_pkg::AngleStagesDef
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_xx,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_xy,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_yy,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_x,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_y,
   input  wire logic signed [COEF_WIDTH-1:0] req_coef_const,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output logic [2:0]                        rsp_conic_kind,
   output logic signed [33:0]                rsp_discriminant,
   output logic                              rsp_center_valid,
   output logic signed [31:0]                rsp_center_x,
   output logic signed [31:0]                rsp_center_y,
   output logic                              rsp_rotation_valid,
   output logic signed [14:0]                rsp_angle,
   output logic                              rsp_axes_valid,
   output logic [31:0]                       rsp_axis_a,
   output logic [31:0]                       rsp_axis_b,
   output logic                              rsp_root_invalid
);
   import csa_pkg::*;

   localparam int CW = COEF_WIDTH;
   localparam int MW = 2*CW+4;
   localparam int NWC = MW + 16;
   localparam int FW = CW + 52;
   localparam int NWA = FW + 16;
   localparam int XW = CW + 32;
   localparam int LAT = 6 + NWC + NWA + SqrtStages;
   localparam int CPRE = LAT - 1 - ANGLE_STAGES;

   typedef struct packed {
      logic              negx;
      logic              negy;
      logic              cval;
      logic              rval;
      logic [2:0]        kind;
      logic [CW-1:0]     a;
      logic [CW-1:0]     c;
      logic [CW-1:0]     d;
      logic [CW-1:0]     e;
      logic [CW-1:0]     f;
      logic [MW-1:0]     delta;
   } side_type;

   typedef struct packed {
      logic [2:0]        kind;
      logic              cval;
      logic              rval;
      logic              aval;
      logic              badx;
      logic              bady;
      logic              az;
      logic              cz;
      logic [31:0]       cx;
      logic [31:0]       cy;
      logic [MW-1:0]     delta;
   } post_type;

   logic en;
   logic [LAT-1:0] vld_ff;
   logic out_vld_ff;
   assign en = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         vld_ff <= {vld_ff[LAT-2:0], req_valid};
         out_vld_ff <= vld_ff[LAT-1];
      end
   end
   assign rsp_valid = out_vld_ff;

   // stage 1: operands
   logic signed [CW-1:0] a_ff, b_ff, c_ff, d_ff, e_ff, f_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         a_ff <= req_coef_xx; b_ff <= req_coef_xy; c_ff <= req_coef_yy;
         d_ff <= req_coef_x;  e_ff <= req_coef_y;  f_ff <= req_coef_const;
      end
   end

   // stage 2: products and flags
   logic signed [MW-1:0] delta_ff, cnum_x_ff, cnum_y_ff;
   logic [2:0] kind_ff;
   logic rval_ff;
   logic signed [CW:0] amc_ff;
   logic signed [CW-1:0] a2_ff, b2_ff, c2_ff, d2_ff, e2_ff, f2_ff;
   logic signed [MW-1:0] dl_w;
   always_comb begin
      dl_w = MW'(b_ff * b_ff) - 4 * MW'(a_ff * c_ff);
   end
   always_ff @(posedge clock) begin
      if (en) begin
         delta_ff <= dl_w;
         cnum_x_ff <= MW'(b_ff * e_ff) - 2 * MW'(c_ff * d_ff);
         cnum_y_ff <= MW'(b_ff * d_ff) - 2 * MW'(a_ff * e_ff);
         rval_ff <= (b_ff != 0) && (a_ff != c_ff);
         amc_ff <= (CW+1)'(a_ff) - (CW+1)'(c_ff);
         a2_ff <= a_ff; b2_ff <= b_ff; c2_ff <= c_ff;
         d2_ff <= d_ff; e2_ff <= e_ff; f2_ff <= f_ff;
         if (dl_w == 0) kind_ff <= (f_ff == 0) ? KIND_DEGENERATE : KIND_PARABOLA;
         else if (dl_w < 0)
            kind_ff <= (b_ff == 0 && a_ff == c_ff) ? KIND_CIRCLE : KIND_ELLIPSE;
         else kind_ff <= KIND_HYPERBOLA;
      end
   end

   // centre dividers: |num|<<16 / |det|, det = -delta
   logic [MW-1:0] mx_w, my_w, md_w;
   assign mx_w = cnum_x_ff < 0 ? MW'(-cnum_x_ff) : MW'(cnum_x_ff);
   assign my_w = cnum_y_ff < 0 ? MW'(-cnum_y_ff) : MW'(cnum_y_ff);
   assign md_w = delta_ff < 0 ? MW'(-delta_ff) : MW'(delta_ff);
   logic [NWC-1:0] qx_w, qy_w;
   csa_div_chain #(.NW(NWC), .DW(MW)) u_divx (
      .clock(clock), .enable(en), .num({mx_w, 16'h0}), .den(md_w), .quo(qx_w));
   csa_div_chain #(.NW(NWC), .DW(MW)) u_divy (
      .clock(clock), .enable(en), .num({my_w, 16'h0}), .den(md_w), .quo(qy_w));

   side_type s2_w, s3_w, s4_ff, s5_ff, s6_ff;
   always_comb begin
      s2_w.negx  = (cnum_x_ff < 0) != (delta_ff > 0);
      s2_w.negy  = (cnum_y_ff < 0) != (delta_ff > 0);
      s2_w.cval  = delta_ff != 0;
      s2_w.rval  = rval_ff;
      s2_w.kind  = kind_ff;
      s2_w.a     = a2_ff;
      s2_w.c     = c2_ff;
      s2_w.d     = d2_ff;
      s2_w.e     = e2_ff;
      s2_w.f     = f2_ff;
      s2_w.delta = delta_ff;
   end
   csa_delay #(.WIDTH($bits(side_type)), .DEPTH(NWC)) u_dly_c (
      .clock(clock), .enable(en), .din(s2_w), .dout(s3_w));

   // saturate centre
   function automatic logic signed [31:0] csat(input logic [NWC-1:0] q,
                                               input logic neg, input logic v);
      logic signed [31:0] r;
      if (!v) r = '0;
      else if (neg) r = (q > NWC'(64'h80000000)) ? 32'sh80000000 : -$signed(q[31:0]);
      else r = (q > NWC'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF : $signed(q[31:0]);
      return r;
   endfunction
   logic signed [31:0] cx_ff, cy_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         cx_ff <= csat(qx_w, s3_w.negx, s3_w.cval);
         cy_ff <= csat(qy_w, s3_w.negy, s3_w.cval);
         s4_ff <= s3_w;
      end
   end

   // squares
   logic [31:0] uh_w, uk_w;
   assign uh_w = cx_ff[31] ? 32'(-cx_ff) : 32'(cx_ff);
   assign uk_w = cy_ff[31] ? 32'(-cy_ff) : 32'(cy_ff);
   logic signed [48:0] hh_ff, kk_ff;
   logic signed [CW+31:0] dh_ff, ek_ff;
   logic signed [31:0] cx5_ff, cy5_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         hh_ff <= $signed({1'b0, 48'((64'(uh_w) * 64'(uh_w)) >> 16)});
         kk_ff <= $signed({1'b0, 48'((64'(uk_w) * 64'(uk_w)) >> 16)});
         dh_ff <= (CW+32)'($signed(s4_ff.d) * cx_ff);
         ek_ff <= (CW+32)'($signed(s4_ff.e) * cy_ff);
         cx5_ff <= cx_ff; cy5_ff <= cy_ff; s5_ff <= s4_ff;
      end
   end

   logic signed [FW-1:0] ah_ff, ck_ff, dhek_ff;
   logic signed [31:0] cx6_ff, cy6_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         ah_ff <= FW'($signed(s5_ff.a) * hh_ff);
         ck_ff <= FW'($signed(s5_ff.c) * kk_ff);
         dhek_ff <= FW'(dh_ff) + FW'(ek_ff) + (FW'($signed(s5_ff.f)) <<< 16);
         s6_ff <= s5_ff;
         cx6_ff <= cx5_ff; cy6_ff <= cy5_ff;
      end
   end

   // fp and axis decision
   logic signed [CW-1:0] a6_w, c6_w;
   assign a6_w = s6_ff.a;
   assign c6_w = s6_ff.c;
   logic signed [FW-1:0] fp_w;
   assign fp_w = ah_ff + ck_ff + dhek_ff;
   logic aval_w, usea_w, badx_w, bady_w;
   always_comb begin
      aval_w = 1'b0;
      usea_w = 1'b0;
      if (s6_ff.cval && !s6_ff.rval) begin
         if ((s6_ff.kind == KIND_CIRCLE || s6_ff.kind == KIND_ELLIPSE) && fp_w < 0)
            aval_w = 1'b1;
         else if (s6_ff.kind == KIND_HYPERBOLA && fp_w != 0) begin
            aval_w = 1'b1; usea_w = 1'b1;
         end
      end
      // num = -fp (positive) here for circle/ellipse; sign mismatch iff den < 0
      badx_w = !usea_w && a6_w < 0;
      bady_w = !usea_w && c6_w < 0;
   end
   logic [FW-1:0] un_w;
   assign un_w = fp_w < 0 ? FW'(-fp_w) : FW'(fp_w);
   logic [CW-1:0] ua_w, uc_w;
   assign ua_w = a6_w < 0 ? CW'(-a6_w) : CW'(a6_w);
   assign uc_w = c6_w < 0 ? CW'(-c6_w) : CW'(c6_w);

   logic [NWA-1:0] qa_w, qc_w;
   csa_div_chain #(.NW(NWA), .DW(CW)) u_diva (
      .clock(clock), .enable(en), .num({un_w, 16'h0}), .den(ua_w), .quo(qa_w));
   csa_div_chain #(.NW(NWA), .DW(CW)) u_divc (
      .clock(clock), .enable(en), .num({un_w, 16'h0}), .den(uc_w), .quo(qc_w));

   post_type p6_w, p7_w, p8_ff, p9_w;
   always_comb begin
      p6_w.kind  = s6_ff.kind;
      p6_w.cval  = s6_ff.cval;
      p6_w.rval  = s6_ff.rval;
      p6_w.aval  = aval_w;
      p6_w.badx  = badx_w;
      p6_w.bady  = bady_w;
      p6_w.az    = a6_w == 0;
      p6_w.cz    = c6_w == 0;
      p6_w.cx    = cx6_ff;
      p6_w.cy    = cy6_ff;
      p6_w.delta = s6_ff.delta;
   end
   csa_delay #(.WIDTH($bits(post_type)), .DEPTH(NWA)) u_dly_a (
      .clock(clock), .enable(en), .din(p6_w), .dout(p7_w));

   // radicand: quotient is |num|<<16/|den|; limit q<2^48 means quo < 2^64
   logic [63:0] rada_ff, radc_ff;
   logic sata_ff, satc_ff;
   always_ff @(posedge clock) begin
      if (en) begin
         rada_ff <= qa_w[63:0];
         radc_ff <= qc_w[63:0];
         sata_ff <= p7_w.az || (qa_w[NWA-1:64] != '0);
         satc_ff <= p7_w.cz || (qc_w[NWA-1:64] != '0);
         p8_ff <= p7_w;
      end
   end
   logic [31:0] rta_w, rtc_w;
   csa_sqrt_chain u_sqa (.clock(clock), .enable(en), .din(rada_ff), .root(rta_w));
   csa_sqrt_chain u_sqc (.clock(clock), .enable(en), .din(radc_ff), .root(rtc_w));
   logic [$bits(post_type)+1:0] pd_w;
   csa_delay #(.WIDTH($bits(post_type)+2), .DEPTH(SqrtStages)) u_dly_s (
      .clock(clock), .enable(en), .din({sata_ff, satc_ff, p8_ff}), .dout(pd_w));
   logic sata9, satc9;
   assign {sata9, satc9, p9_w} = pd_w;

   // CORDIC, aligned to the end of the pipe
   logic [2*CW:0] rot_w;
   logic signed [CW:0] amcd_w;
   logic signed [CW-1:0] bd_w;
   csa_delay #(.WIDTH(2*CW+1), .DEPTH(CPRE - 2)) u_dly_r (
      .clock(clock), .enable(en), .din({amc_ff, b2_ff}), .dout(rot_w));
   assign amcd_w = rot_w[2*CW:CW];
   assign bd_w = rot_w[CW-1:0];
   logic signed [XW-1:0] cx0_ff, cy0_ff;
   logic signed [33:0] cz0_ff;
   logic signed [XW-1:0] sx_w, sy_w;
   assign sx_w = XW'(amcd_w) <<< 14;
   assign sy_w = XW'(bd_w) <<< 14;
   always_ff @(posedge clock) begin
      if (en) begin
         if (sx_w < 0) begin
            if (sy_w >= 0) begin
               cx0_ff <= sy_w; cy0_ff <= -sx_w; cz0_ff <= 34'(HalfPiZ);
            end else begin
               cx0_ff <= -sy_w; cy0_ff <= sx_w; cz0_ff <= -34'(HalfPiZ);
            end
         end else begin
            cx0_ff <= sx_w; cy0_ff <= sy_w; cz0_ff <= '0;
         end
      end
   end
   logic signed [33:0] zf_w;
   csa_cordic_chain #(.STAGES(ANGLE_STAGES), .XW(XW)) u_cordic (
      .clock(clock), .enable(en), .x0(cx0_ff), .y0(cy0_ff), .z0(cz0_ff), .z_out(zf_w));
   logic signed [34:0] zr_w;
   logic signed [14:0] ang_w;
   always_comb begin
      zr_w = (35'(zf_w) + 35'sd131072) >>> 18;
      if (zr_w > AngleLimit) ang_w = 15'(AngleLimit);
      else if (zr_w < -AngleLimit) ang_w = -15'(AngleLimit);
      else ang_w = 15'(zr_w);
   end

   // output register
   always_ff @(posedge clock) begin
      if (en) begin
         rsp_conic_kind <= p9_w.kind;
         rsp_discriminant <= 34'(p9_w.delta);
         rsp_center_valid <= p9_w.cval;
         rsp_center_x <= p9_w.cx;
         rsp_center_y <= p9_w.cy;
         rsp_rotation_valid <= p9_w.rval;
         rsp_angle <= p9_w.rval ? ang_w : '0;
         rsp_axes_valid <= p9_w.aval;
         rsp_axis_a <= !p9_w.aval ? '0 : p9_w.az ? 32'hFFFFFFFF : p9_w.badx ? '0 :
                       sata9 ? 32'hFFFFFFFF : rta_w;
         rsp_axis_b <= !p9_w.aval ? '0 : p9_w.cz ? 32'hFFFFFFFF : p9_w.bady ? '0 :
                       satc9 ? 32'hFFFFFFFF : rtc_w;
         rsp_root_invalid <= p9_w.aval && ((p9_w.badx && !p9_w.az) ||
                                           (p9_w.bady && !p9_w.cz));
      end
   end
endmodule
`default_nettype wire

/* tb/csa_checker.sv */
module csa_checker
   import csa_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic signed [15:0] req_coef_xx,
   input  wire logic signed [15:0] req_coef_xy,
   input  wire logic signed [15:0] req_coef_yy,
   input  wire logic signed [15:0] req_coef_x,
   input  wire logic signed [15:0] req_coef_y,
   input  wire logic signed [15:0] req_coef_const,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [2:0]         rsp_conic_kind,
   input  wire logic signed [33:0] rsp_discriminant,
   input  wire logic               rsp_center_valid,
   input  wire logic signed [31:0] rsp_center_x,
   input  wire logic signed [31:0] rsp_center_y,
   input  wire logic               rsp_rotation_valid,
   input  wire logic signed [14:0] rsp_angle,
   input  wire logic               rsp_axes_valid,
   input  wire logic [31:0]        rsp_axis_a,
   input  wire logic [31:0]        rsp_axis_b,
   input  wire logic               rsp_root_invalid,
   output int                      mismatches,
   output int                      pending,
   output int                      checked,
   output int                      kind_seen [5]
);
   typedef struct packed {
      logic [2:0]         kind;
      logic signed [33:0] disc;
      logic               cval;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic               rval;
      logic signed [14:0] ang;
      logic               aval;
      logic [31:0]        ax;
      logic [31:0]        bx;
      logic               bad;
   } conic_result_t;

   conic_result_t expected_results[$];

   function automatic longint unsigned absval(longint v);
      return v < 0 ? longint'(-v) : v;
   endfunction

   function automatic longint centre_quot(longint num, longint den);
      longint unsigned q;
      q = (absval(num) << 16) / absval(den);
      if ((num < 0) != (den < 0))
         return q > 64'd2147483648 ? -64'sd2147483648 : -longint'(q);
      return q > 64'd2147483647 ? 64'sd2147483647 : longint'(q);
   endfunction

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v -= res + bitv;
            res = (res >> 1) + bitv;
         end else begin
            res >>= 1;
         end
         bitv >>= 2;
      end
      return res;
   endfunction

   function automatic longint unsigned semi_axis(longint num, longint den, bit use_abs,
                                                 inout bit bad);
      longint unsigned un, ud, q, rem;
      if (den == 0) return 64'hFFFF_FFFF;
      if (!use_abs && num != 0 && ((num < 0) != (den < 0))) begin
         bad = 1;
         return 0;
      end
      un = absval(num);
      ud = absval(den);
      q = un / ud;
      rem = un % ud;
      if (q >= (64'd1 << 48)) return 64'hFFFF_FFFF;
      return int_sqrt((q << 16) + ((rem << 16) / ud));
   endfunction

   function automatic longint rotation_angle(longint dx, longint dy);
      longint x, y, z, nx, ny, r;
      x = dx * 16384;
      y = dy * 16384;
      z = 0;
      if (x < 0) begin
         if (y >= 0) begin
            nx = y; ny = -x; z = longint'(HalfPiZ);
         end else begin
            nx = -y; ny = x; z = -longint'(HalfPiZ);
         end
         x = nx; y = ny;
      end
      for (int i = 0; i < AngleStagesDef && i < 32; i++) begin
         if (y > 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += longint'(atan_entry(i));
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= longint'(atan_entry(i));
         end
         x = nx; y = ny;
      end
      r = (z + (64'sd1 << 17)) >>> 18;
      if (r > AngleLimit) r = AngleLimit;
      if (r < -AngleLimit) r = -AngleLimit;
      return r;
   endfunction

   function automatic conic_result_t analyse_conic(longint a, longint b, longint c,
                                                   longint d, longint e, longint f);
      conic_result_t res;
      longint delta, det, fp, hh, kk, cx, cy;
      longint unsigned ax, bx;
      bit bad;
      res = '0;
      cx = 0; cy = 0; ax = 0; bx = 0; bad = 0;
      delta = b * b - 4 * a * c;
      det = -delta;
      if (delta == 0) res.kind = (f == 0) ? KIND_DEGENERATE : KIND_PARABOLA;
      else if (delta < 0) res.kind = (b == 0 && a == c) ? KIND_CIRCLE : KIND_ELLIPSE;
      else res.kind = KIND_HYPERBOLA;
      res.disc = delta[33:0];
      if (det != 0) begin
         res.cval = 1;
         cx = centre_quot(b * e - 2 * c * d, det);
         cy = centre_quot(b * d - 2 * a * e, det);
      end
      if (b != 0 && a != c) begin
         res.rval = 1;
         res.ang = 15'(rotation_angle(a - c, b));
      end
      if (res.cval && !res.rval) begin
         hh = longint'((absval(cx) * absval(cx)) >> 16);
         kk = longint'((absval(cy) * absval(cy)) >> 16);
         fp = a * hh + c * kk + d * cx + e * cy + f * 65536;
         if (res.kind == KIND_CIRCLE && fp < 0) begin
            res.aval = 1;
            ax = semi_axis(-fp, a, 0, bad);
            bx = ax;
         end else if (res.kind == KIND_ELLIPSE && fp < 0) begin
            res.aval = 1;
            ax = semi_axis(-fp, a, 0, bad);
            bx = semi_axis(-fp, c, 0, bad);
         end else if (res.kind == KIND_HYPERBOLA && fp != 0) begin
            res.aval = 1;
            ax = semi_axis(fp, a, 1, bad);
            bx = semi_axis(fp, c, 1, bad);
         end
      end
      res.cx = cx[31:0];
      res.cy = cy[31:0];
      res.ax = ax[31:0];
      res.bx = bx[31:0];
      res.bad = bad;
      return res;
   endfunction

   conic_result_t got, want;

   initial begin
      mismatches = 0;
      pending = 0;
      checked = 0;
      foreach (kind_seen[i]) kind_seen[i] = 0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && req_ready)
         expected_results.push_back(analyse_conic(req_coef_xx, req_coef_xy, req_coef_yy,
                                                  req_coef_x, req_coef_y, req_coef_const));
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_conic_kind, rsp_discriminant, rsp_center_valid, rsp_center_x,
                 rsp_center_y, rsp_rotation_valid, rsp_angle, rsp_axes_valid,
                 rsp_axis_a, rsp_axis_b, rsp_root_invalid};
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response transfer: %p", got);
         end else begin
            want = expected_results.pop_front();
            checked++;
            if (want.kind < 5) kind_seen[want.kind]++;
            if (got.kind !== want.kind || got.disc !== want.disc || got.cval !== want.cval ||
                got.cx !== want.cx || got.cy !== want.cy || got.rval !== want.rval ||
                got.ang !== want.ang || got.aval !== want.aval || got.ax !== want.ax ||
                got.bx !== want.bx || got.bad !== want.bad) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch on response %0d", checked);
                  $display("  expected %p", want);
                  $display("  actual   %p", got);
               end
            end
         end
      end
      pending <= expected_results.size();
   end
endmodule

/* tb/conic_section_analyzer_unit_tb.sv */
module conic_section_analyzer_unit_tb;
   import csa_pkg::*;

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_ready;
   logic signed [15:0] req_coef_xx = 0, req_coef_xy = 0, req_coef_yy = 0;
   logic signed [15:0] req_coef_x = 0, req_coef_y = 0, req_coef_const = 0;
   logic               rsp_valid;
   logic               rsp_ready = 0;
   logic [2:0]         rsp_conic_kind;
   logic signed [33:0] rsp_discriminant;
   logic               rsp_center_valid;
   logic signed [31:0] rsp_center_x, rsp_center_y;
   logic               rsp_rotation_valid;
   logic signed [14:0] rsp_angle;
   logic               rsp_axes_valid;
   logic [31:0]        rsp_axis_a, rsp_axis_b;
   logic               rsp_root_invalid;
   int                 mismatches, pending, checked;
   int                 kind_seen [5];

   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int hold_left = 0;
   int sent = 0;

   conic_section_analyzer_unit u_dut (.*);
   csa_checker u_checker (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   task automatic send_conic(logic signed [15:0] a, b, c, d, e, f);
      if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_valid <= 0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_valid <= 1;
      req_coef_xx <= a; req_coef_xy <= b; req_coef_yy <= c;
      req_coef_x <= d; req_coef_y <= e; req_coef_const <= f;
      do @(posedge clock); while (!req_ready);
      sent++;
   endtask

   function automatic logic signed [15:0] pick_coef();
      case ($urandom_range(5))
         0: return 16'($urandom);
         1: return 16'($signed($urandom_range(512)) - 256);
         2: return 16'($signed($urandom_range(4096)) - 2048);
         3: return $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
         4: return '0;
         default: return 16'($signed($urandom_range(64)) - 32);
      endcase
   endfunction

   task automatic send_random();
      logic signed [15:0] a, b, c, d, e, f;
      int p, q;
      a = pick_coef(); b = pick_coef(); c = pick_coef();
      d = pick_coef(); e = pick_coef(); f = pick_coef();
      case ($urandom_range(7))
         0: begin b = 0; c = a; end
         1: b = 0;
         2: begin
            p = $signed($urandom_range(180)) - 90;
            q = $signed($urandom_range(180)) - 90;
            a = 16'(p * p); c = 16'(q * q); b = 16'(2 * p * q);
            if ($urandom_range(1)) f = 0;
         end
         3: begin b = 0; a = -a; end
         default: ;
      endcase
      send_conic(a, b, c, d, e, f);
   endtask

   task automatic drain();
      while (pending != 0 || rsp_valid) @(posedge clock);
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      send_conic(16'sh0100, 0, 16'sh0100, 0, 0, -16'sh0400);
      send_conic(16'sh0100, 0, 16'sh0400, 0, 0, -16'sh0100);
      send_conic(16'sh0100, 0, -16'sh0100, 0, 0, 16'sh0100);
      send_conic(16'sh0100, 16'sh0200, 16'sh0100, 16'sh0100, 0, 16'sh0100);
      send_conic(16'sh0100, 16'sh0200, 16'sh0100, 16'sh0100, 0, 0);
      send_conic(16'sh0100, 0, 16'sh0100, 0, 0, 16'sh0100);
      send_conic(16'sh0100, 0, -16'sh0100, 0, 0, 0);
      send_conic(0, 0, 0, 0, 0, 0);
      send_conic(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      send_conic(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
      send_conic(16'sh8000, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_conic(16'sh0001, 0, 16'sh0001, 16'sh7FFF, 16'sh8000, 16'sh8000);
      send_conic(0, 16'sh0100, 0, 16'sh0100, 16'sh0100, 16'sh0100);
      send_conic(16'sh0100, 0, 0, 16'sh0100, 16'sh0100, 16'sh0100);
      send_conic(0, 0, 16'sh0100, 16'sh0100, 16'sh0100, 16'sh0100);
      send_conic(-16'sh0100, 16'sh0100, 16'sh0100, 0, 0, 16'sh0100);
      send_conic(-16'sh0100, -16'sh0100, 16'sh0100, 0, 0, 16'sh0100);
      send_conic(16'sh0300, -16'sh0100, 16'sh0100, 0, 0, 16'sh0100);
      send_conic(16'sh0100, 16'sh0001, 16'sh0100, 16'sh8000, 16'sh7FFF, 16'sh8000);
      send_conic(16'shFFFF, 0, 16'shFFFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
            default: begin send_idle_pct = 29; recv_stall_pct = 29; end
         endcase
         if (phase == 0) hold_left = 500;
         repeat (370) send_random();
      end
      req_valid <= 0;
      drain();
      repeat (300) @(posedge clock);
      $display("%0d conic sets sent, %0d responses checked, over four handshake phases",
               sent, checked);
      $display("kinds: circle %0d ellipse %0d parabola %0d hyperbola %0d degenerate %0d",
               kind_seen[0], kind_seen[1], kind_seen[2], kind_seen[3], kind_seen[4]);
      if (mismatches == 0 && pending == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #30000000;
      $display("TEST FAILED");
      $finish;
   end
endmodule
